// File: design/kls_pkg.sv
// Shared types and codes for the key table search unit.
// Holds request/response codes and the response struct; no dependencies.
package kls_pkg;

   localparam int KEY_W          = 64;   // width of the key field on the request side
   localparam int POS_W          = 6;    // width of the position field
   localparam int RSP_DATA_W     = 8;    // position padded to whole bytes
   localparam int ENTRIES_DEF    = 32;
   localparam int KEY_BITS_DEF   = 64;

   // request kinds (req_tuser)
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_BINARY = 2'd2;

   // response status (rsp_tuser)
   localparam logic [1:0] ST_ADDED    = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_FOUND    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] position;
      logic             last;
   } rsp_type;

endpackage

// File: design/kls_key_mem.sv
// Key storage: one write port, one read port with registered read data.
// Read data holds its value while no read is issued. No dependencies.
module kls_key_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/kls_rsp_reg.sv
// Response output register between the sequencer and the rsp_ stream.
// Depends on kls_pkg for the response struct and field widths.
module kls_rsp_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  kls_pkg::rsp_type                  result,
   output logic                              out_free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kls_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [5:0] position, [7:6] zero
   output logic [1:0]                        rsp_tuser,   // [1:0] status
   output logic                              rsp_tlast
);
   import kls_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // a slot is free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POS_W){1'b0}}, data_ff.position};
   assign rsp_tuser  = data_ff.status;
   assign rsp_tlast  = data_ff.last;

endmodule

// File: design/kls_seq.sv
// Sequencer: fill count, add path, linear scan and binary search over the key memory.
// Depends on kls_pkg; drives kls_key_mem ports and pushes into kls_rsp_reg.
module kls_seq #(
   parameter int ENTRIES  = kls_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = kls_pkg::KEY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_mode,
   input  logic [kls_pkg::KEY_W-1:0]  req_key,
   output logic                       wr_en,
   output logic [$clog2(ENTRIES)-1:0] wr_addr,
   output logic [KEY_BITS-1:0]        wr_data,
   output logic                       rd_en,
   output logic [$clog2(ENTRIES)-1:0] rd_addr,
   input  logic [KEY_BITS-1:0]        rd_data,
   input  logic                       out_free,
   output logic                       push,
   output kls_pkg::rsp_type           result
);
   import kls_pkg::*;

   localparam int IDXW = $clog2(ENTRIES);
   localparam int CNTW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {IDLE, SCAN, FLUSH, BSRCH} state_type;

   state_type         state_ff, state_in;
   logic [CNTW-1:0]   fill_ff, fill_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IDXW-1:0]   idx_ff, idx_in;      // scan index or binary probe index
   logic [CNTW-1:0]   lo_ff, lo_in;        // binary range [lo, hi1)
   logic [CNTW-1:0]   hi1_ff, hi1_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [POS_W-1:0]  pend_pos_ff, pend_pos_in;

   logic              req_fire;
   logic              match;
   logic              key_gt;
   logic              scan_final;
   logic [CNTW-1:0]   idx_next;
   logic [CNTW-1:0]   lo_next;
   logic [CNTW-1:0]   hi_next;
   logic              bin_done;
   logic [CNTW:0]     mid_sum;
   logic [CNTW:0]     first_sum;

   assign req_ready  = (state_ff == IDLE) && out_free;
   assign req_fire   = req_valid && req_ready;
   assign match      = (rd_data == key_ff);
   assign key_gt     = (key_ff > rd_data);
   assign idx_next   = CNTW'(idx_ff) + CNTW'(1);
   assign scan_final = (idx_next == fill_ff);
   assign lo_next    = key_gt ? idx_next : lo_ff;
   assign hi_next    = key_gt ? hi1_ff : CNTW'(idx_ff);
   assign bin_done   = match || !(lo_next < hi_next);
   // floor midpoint of the inclusive range [lo, hi1-1]
   assign mid_sum    = {1'b0, lo_next} + {1'b0, hi_next} - (CNTW+1)'(1);
   assign first_sum  = {1'b0, fill_ff} - (CNTW+1)'(1);

   assign wr_addr = IDXW'(fill_ff);
   assign wr_data = key_in;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi1_in        = hi1_ff;
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      push          = 1'b0;
      result        = '{status: ST_NOTFOUND, position: '0, last: 1'b1};

      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               key_in = req_key[KEY_BITS-1:0];
               unique case (req_mode)
                  MODE_ADD: begin
                     push = 1'b1;
                     if (fill_ff == CNTW'(ENTRIES)) begin
                        result.status = ST_FULL;
                     end else begin
                        result.status = ST_ADDED;
                        wr_en         = 1'b1;
                        fill_in       = fill_ff + CNTW'(1);
                     end
                  end
                  MODE_LINEAR: begin
                     if (fill_ff == '0) begin
                        push = 1'b1;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        idx_in        = '0;
                        pend_valid_in = 1'b0;
                        state_in      = SCAN;
                     end
                  end
                  MODE_BINARY: begin
                     if (fill_ff == '0) begin
                        push = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IDXW'(first_sum[CNTW:1]);
                        idx_in   = IDXW'(first_sum[CNTW:1]);
                        lo_in    = '0;
                        hi1_in   = fill_ff;
                        state_in = BSRCH;
                     end
                  end
                  default: begin
                     // unused kind: dropped without a response
                  end
               endcase
            end
         end
         SCAN: begin
            // a match is held back until the next match or the flush so the final one can carry last
            if (!(match && pend_valid_ff && !out_free)) begin
               if (match) begin
                  if (pend_valid_ff) begin
                     push   = 1'b1;
                     result = '{status: ST_FOUND, position: pend_pos_ff, last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_pos_in   = POS_W'(idx_next);
               end
               if (scan_final) begin
                  state_in = FLUSH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = IDXW'(idx_next);
                  idx_in  = IDXW'(idx_next);
               end
            end
         end
         FLUSH: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = IDLE;
               if (pend_valid_ff) begin
                  result = '{status: ST_FOUND, position: pend_pos_ff, last: 1'b1};
               end
            end
         end
         BSRCH: begin
            if (bin_done) begin
               if (out_free) begin
                  push     = 1'b1;
                  state_in = IDLE;
                  if (match) begin
                     result = '{status: ST_FOUND, position: POS_W'(idx_next), last: 1'b1};
                  end
               end
            end else begin
               lo_in   = lo_next;
               hi1_in  = hi_next;
               rd_en   = 1'b1;
               rd_addr = IDXW'(mid_sum[CNTW:1]);
               idx_in  = IDXW'(mid_sum[CNTW:1]);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
      end
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi1_ff      <= hi1_in;
      pend_pos_ff <= pend_pos_in;
   end

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == MODE_ADD && fill_ff != CNTW'(ENTRIES))
         |=> (fill_ff == $past(fill_ff) + CNTW'(1)))
      else $error("fill count did not advance on add");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (CNTW'(rd_addr) < fill_ff))
      else $error("read beyond filled entries");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("response pushed into a full output register");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BSRCH) |-> (lo_ff < hi1_ff && CNTW'(idx_ff) >= lo_ff
                               && CNTW'(idx_ff) < hi1_ff))
      else $error("binary probe outside live range");

endmodule

// File: design/key_table_linear_binary_search_unit.sv
// Key table with linear and binary search.
// Requests arrive on req_: tuser is the kind (0 add, 1 linear search,
// 2 binary search, 3 dropped), tdata the 64-bit key (low KEY_BITS used).
// Responses leave on rsp_: tuser is the status (0 added, 1 full, 2 found,
// 3 not found), tdata[5:0] the 1-based position, tlast marks the final
// response of a request.
// A linear search reads one key memory entry per cycle, unless a held match
// waits for the output register, then flushes the held match; a binary search
// probes the floor midpoint of its live range until a match or an empty range.
// A new request is taken only when the previous one is finished and the
// output register is empty or draining, so the rate is set by the single
// read port of the key memory walked by the sequencer.
// Adds write the memory in the accept cycle; any later read is issued after
// that write has landed, so no forwarding is needed.
// Reset clears the fill count and control state; key memory is not cleared.
// A stalled rsp_tready holds the response and, once the register is full,
// the search pauses until it drains.
// Depends on kls_pkg, kls_key_mem, kls_seq and kls_rsp_reg.
module key_table_linear_binary_search_unit #(
   parameter int ENTRIES  = kls_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = kls_pkg::KEY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kls_pkg::KEY_W-1:0]      req_tdata,   // [63:0] key
   input  logic [1:0]                     req_tuser,   // [1:0] mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [kls_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [5:0] position, [7:6] zero
   output logic [1:0]                     rsp_tuser,   // [1:0] status
   output logic                           rsp_tlast
);
   import kls_pkg::*;

   localparam int IDXW = $clog2(ENTRIES);

   logic                wr_en;
   logic [IDXW-1:0]     wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic                rd_en;
   logic [IDXW-1:0]     rd_addr;
   logic [KEY_BITS-1:0] rd_data;
   logic                out_free;
   logic                push;
   rsp_type             result;

   kls_key_mem #(
      .DEPTH (ENTRIES),
      .WIDTH (KEY_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kls_seq #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_key   (req_tdata),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_free  (out_free),
      .push      (push),
      .result    (result)
   );

   kls_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: verif/key_table_linear_binary_search_unit_test.sv
// Testbench for the key table search unit: adds, linear and binary searches.
// A local table model predicts every response; depends on kls_pkg and the unit RTL.
module key_table_linear_binary_search_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kls_pkg::*;

   localparam int TABLE_DEPTH = ENTRIES_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid;
   logic req_tready;
   logic [KEY_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   // table model
   logic [KEY_W-1:0] key_table [TABLE_DEPTH];
   int table_fill = 0;
   rsp_type pending_rsp [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int quiet_cycles = 0;

   key_table_linear_binary_search_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] status, int position, logic last);
      rsp_type r;
      r.status = status;
      r.position = position[POS_W-1:0];
      r.last = last;
      return r;
   endfunction

   // Expected responses for one accepted request; updates the table model.
   task automatic predict_table_responses(input logic [1:0] mode, input logic [KEY_W-1:0] key);
      int hits;
      int seen;
      int lo;
      int hi;
      int mid;
      bit found;
      hits = 0;
      seen = 0;
      found = 0;
      case (mode)
         MODE_ADD: begin
            if (table_fill >= TABLE_DEPTH) begin
               pending_rsp.push_back(make_rsp(ST_FULL, 0, 1'b1));
            end else begin
               key_table[table_fill] = key;
               table_fill++;
               pending_rsp.push_back(make_rsp(ST_ADDED, 0, 1'b1));
            end
         end
         MODE_LINEAR: begin
            for (int s = 0; s < table_fill; s++) begin
               if (key_table[s] == key) hits++;
            end
            if (hits == 0) begin
               pending_rsp.push_back(make_rsp(ST_NOTFOUND, 0, 1'b1));
            end else begin
               for (int s = 0; s < table_fill; s++) begin
                  if (key_table[s] == key) begin
                     seen++;
                     pending_rsp.push_back(make_rsp(ST_FOUND, s + 1, seen == hits));
                  end
               end
            end
         end
         MODE_BINARY: begin
            lo = 0;
            hi = table_fill - 1;
            while (lo <= hi && !found) begin
               mid = (lo + hi) / 2;
               if (key_table[mid] == key) begin
                  found = 1;
                  pending_rsp.push_back(make_rsp(ST_FOUND, mid + 1, 1'b1));
               end else if (key > key_table[mid]) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
            if (!found) pending_rsp.push_back(make_rsp(ST_NOTFOUND, 0, 1'b1));
         end
         default: ;  // unused mode: dropped by the unit
      endcase
   endtask

   // Entered and left at a falling edge; tvalid stays high when requests follow back to back.
   task automatic send_request(input logic [1:0] mode, input logic [KEY_W-1:0] key);
      int idle;
      idle = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_table_responses(mode, key);
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   function automatic logic [KEY_W-1:0] pick_search_key();
      int r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(99);
      if (table_fill != 0 && r < 45) return key_table[$urandom_range(table_fill - 1)];
      if (table_fill != 0 && r < 60) begin
         k = key_table[$urandom_range(table_fill - 1)];
         return r[0] ? k + 1 : k - 1;
      end
      if (r < 85) return rand_key();
      if (r < 93) return r[0] ? '0 : '1;
      return 64'd1 << $urandom_range(KEY_W - 1);
   endfunction

   // Next key of a nondecreasing fill; a step of zero makes a duplicate.
   function automatic logic [KEY_W-1:0] next_sorted_key();
      logic [KEY_W-1:0] prev;
      logic [KEY_W-1:0] span;
      prev = key_table[table_fill - 1];
      span = ~prev / (TABLE_DEPTH - 2 - table_fill);
      if ($urandom_range(5) == 0) return prev;
      return prev + rand_key() % ((span >> 1) + 1);
   endfunction

   task automatic test_empty_table();
      send_request(MODE_LINEAR, '0);
      send_request(MODE_BINARY, '1);
      send_request(MODE_UNUSED, '1);
      send_request(MODE_UNUSED, '0);
      send_request(MODE_LINEAR, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(MODE_BINARY, 64'h5555_5555_5555_5555);
   endtask

   task automatic test_duplicate_keys();
      send_request(MODE_ADD, '0);
      send_request(MODE_LINEAR, '0);
      send_request(MODE_BINARY, '0);
      send_request(MODE_BINARY, '1);
      send_request(MODE_ADD, '0);
      send_request(MODE_LINEAR, '0);
      send_request(MODE_BINARY, '0);
      send_request(MODE_LINEAR, '1);
   endtask

   // Sorted fill with searches in between; the last two slots hold the
   // largest key and then an older duplicate, which leaves the table unsorted.
   task automatic test_fill_table();
      int r;
      while (table_fill < TABLE_DEPTH - 2) begin
         r = $urandom_range(99);
         if (r < 40) send_request(MODE_ADD, next_sorted_key());
         else if (r < 45) send_request(MODE_UNUSED, rand_key());
         else send_request(r[0] ? MODE_LINEAR : MODE_BINARY, pick_search_key());
      end
      send_request(MODE_ADD, '1);
      send_request(MODE_BINARY, '1);
      send_request(MODE_ADD, key_table[$urandom_range(2, TABLE_DEPTH - 4)]);
   endtask

   task automatic test_full_table(input int requests);
      int r;
      send_request(MODE_ADD, rand_key());
      repeat (requests) begin
         r = $urandom_range(99);
         if (r < 8) send_request(MODE_ADD, rand_key());
         else if (r < 14) send_request(MODE_UNUSED, rand_key());
         else send_request(r[0] ? MODE_LINEAR : MODE_BINARY, pick_search_key());
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: status %0d position %0d last %0d",
                   rsp_tuser, rsp_tdata[POS_W-1:0], rsp_tlast);
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[POS_W-1:0] !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_tdata[POS_W-1:0]);
               failures++;
            end
            if (rsp_tdata[RSP_DATA_W-1:POS_W] !== '0) begin
               $error("tdata padding: expected 0, got %0d", rsp_tdata[RSP_DATA_W-1:POS_W]);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_ADD;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_duplicate_keys();
      wait_for_responses();

      send_idle_pct = 54;
      test_fill_table();
      wait_for_responses();

      send_idle_pct = 0;
      stall_pct = 54;
      test_full_table(110);
      wait_for_responses();

      send_idle_pct = 26;
      stall_pct = 26;
      test_full_table(110);

      send_idle_pct = 0;
      stall_pct = 0;
      test_full_table(110);
      wait_for_responses();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
